/* hdl/cmnf_pkg.sv */
// Shared types, constants and the five-point median for the cross median filter.
package cmnf_pkg;

  localparam int PIX_W          = 32;
  localparam int FRAME_WIDTH_W  = 13;
  localparam int FRAME_HEIGHT_W = 11;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [4:0][PIX_W-1:0] word5_t;

  // Per-beat command from the sequencer to the filter stage.
  typedef struct packed {
    logic res;
    logic has_left;
    logic has_up;
    logic has_right;
    logic has_below;
    logic last;
  } cmd_t;

  // Stable rank of each word (signed compare, ties by position); rank two is the median.
  function automatic logic [PIX_W-1:0] median5(input word5_t v);
    logic [4:0][2:0] rank;
    logic [PIX_W-1:0] m;
    rank = '0;
    m = v[0];
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        if (j != i) begin
          if (($signed(v[j]) < $signed(v[i])) || ((v[j] == v[i]) && (j < i))) begin
            rank[i] = rank[i] + 3'd1;
          end
        end
      end
    end
    for (int i = 0; i < 5; i++) begin
      if (rank[i] == 3'd2) begin
        m = v[i];
      end
    end
    return m;
  endfunction

endpackage

/* hdl/cmnf_in_if.sv */
// Input pixel stream channel.
interface cmnf_in_if;
  logic                        valid;
  logic                        ready;
  logic [cmnf_pkg::PIX_W-1:0]  pixel_in;
  logic                        drain;

  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

/* hdl/cmnf_out_if.sv */
// Filtered pixel result channel.
interface cmnf_out_if;
  logic                        valid;
  logic                        ready;
  logic [cmnf_pkg::PIX_W-1:0]  pixel_out;
  logic                        frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

/* hdl/cmnf_ring_mem.sv */
// Raw pixel ring: one write port, two registered read ports.
module cmnf_ring_mem #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [cmnf_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [cmnf_pkg::PIX_W-1:0] rdata_a,
  output logic [cmnf_pkg::PIX_W-1:0] rdata_b
);

  logic [cmnf_pkg::PIX_W-1:0] mem [DEPTH];
  logic [cmnf_pkg::PIX_W-1:0] rdata_a_r;
  logic [cmnf_pkg::PIX_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* hdl/cmnf_fcol_mem.sv */
// Filtered previous column store: one write port, one registered read port.
module cmnf_fcol_mem #(
  parameter int DEPTH = 1024,
  parameter int RW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [RW-1:0]              waddr,
  input  logic [cmnf_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [RW-1:0]              raddr,
  output logic [cmnf_pkg::PIX_W-1:0] rdata
);

  logic [cmnf_pkg::PIX_W-1:0] mem [DEPTH];
  logic [cmnf_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/cmnf_seq.sv */
// Scan sequencer: frame counters, ring addressing and per-beat commands.
module cmnf_seq #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 1024,
  parameter int AW         = 11,
  parameter int RW         = 10,
  parameter int CW         = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cmnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmnf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             acc,
  input  logic                             drain,
  output logic                             ring_we,
  output logic [AW-1:0]                    ring_waddr,
  output logic [AW-1:0]                    ring_raddr_c,
  output logic [AW-1:0]                    ring_raddr_b,
  output logic [RW-1:0]                    fcol_raddr,
  output cmnf_pkg::cmd_t                   cmd,
  output logic [RW-1:0]                    cmd_row
);

  localparam logic [31:0] W_RST = (cmnf_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                  32'(MAX_WIDTH) : 32'(cmnf_pkg::FRAME_WIDTH_RST);
  localparam logic [31:0] H_RST = (cmnf_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                                  32'(MAX_HEIGHT) : 32'(cmnf_pkg::FRAME_HEIGHT_RST);

  logic [CW-1:0] wm1_r, wm1_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [RW-1:0] hm1_r, hm1_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic          out_col_nz_r, out_col_nz_nxt;
  logic          rcvd_r, rcvd_nxt;

  logic        pix_acc;
  logic        flush;
  logic        res;
  logic [31:0] wv, weff, hv, heff;

  assign pix_acc = acc && !rcvd_r && !drain;
  assign flush   = acc && rcvd_r;
  assign res     = (pix_acc && (in_col_r != '0)) || flush;

  assign ring_we    = pix_acc;
  assign ring_waddr = head_r;
  assign fcol_raddr = out_row_r;

  always_comb begin
    ring_raddr_c = (head_r == h_r) ? '0 : head_r + AW'(1);
    if (head_r == h_r) begin
      ring_raddr_b = AW'(1);
    end else if (head_r == h_r - AW'(1)) begin
      ring_raddr_b = '0;
    end else begin
      ring_raddr_b = head_r + AW'(2);
    end
  end

  always_comb begin
    cmd.res       = res;
    cmd.has_left  = out_col_nz_r;
    cmd.has_up    = (out_row_r != '0);
    cmd.has_right = !rcvd_r;
    cmd.has_below = (out_row_r != hm1_r);
    cmd.last      = rcvd_r && (out_row_r == hm1_r);
    cmd_row       = out_row_r;
  end

  // Clamp register writes to the supported frame size.
  always_comb begin
    wv   = 32'(cfg_wdata[cmnf_pkg::FRAME_WIDTH_W-1:0]);
    hv   = 32'(cfg_wdata[cmnf_pkg::FRAME_HEIGHT_W-1:0]);
    weff = (wv == 32'd0) ? 32'd1 : ((wv > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : wv);
    heff = (hv == 32'd0) ? 32'd1 : ((hv > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : hv);
  end

  always_comb begin
    wm1_nxt        = wm1_r;
    h_nxt          = h_r;
    hm1_nxt        = hm1_r;
    head_nxt       = head_r;
    in_row_nxt     = in_row_r;
    in_col_nxt     = in_col_r;
    out_row_nxt    = out_row_r;
    out_col_nz_nxt = out_col_nz_r;
    rcvd_nxt       = rcvd_r;
    if (cfg_we) begin
      case (cfg_index)
        cmnf_pkg::REG_FRAME_WIDTH: begin
          wm1_nxt = CW'(weff - 32'd1);
        end
        cmnf_pkg::REG_FRAME_HEIGHT: begin
          h_nxt   = AW'(heff);
          hm1_nxt = RW'(heff - 32'd1);
        end
        default: begin
        end
      endcase
      head_nxt       = '0;
      in_row_nxt     = '0;
      in_col_nxt     = '0;
      out_row_nxt    = '0;
      out_col_nz_nxt = 1'b0;
      rcvd_nxt       = 1'b0;
    end else if (pix_acc || flush) begin
      head_nxt = (head_r == h_r) ? '0 : head_r + AW'(1);
      if (res) begin
        if (out_row_r == hm1_r) begin
          out_row_nxt    = '0;
          out_col_nz_nxt = 1'b1;
        end else begin
          out_row_nxt = out_row_r + RW'(1);
        end
      end
      if (pix_acc) begin
        if (in_row_r == hm1_r) begin
          in_row_nxt = '0;
          if (in_col_r == wm1_r) begin
            in_col_nxt = '0;
            rcvd_nxt   = 1'b1;
          end else begin
            in_col_nxt = in_col_r + CW'(1);
          end
        end else begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end
      if (flush && (out_row_r == hm1_r)) begin
        head_nxt       = '0;
        in_row_nxt     = '0;
        in_col_nxt     = '0;
        out_row_nxt    = '0;
        out_col_nz_nxt = 1'b0;
        rcvd_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r        <= CW'(W_RST - 32'd1);
      h_r          <= AW'(H_RST);
      hm1_r        <= RW'(H_RST - 32'd1);
      head_r       <= '0;
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_nz_r <= 1'b0;
      rcvd_r       <= 1'b0;
    end else begin
      wm1_r        <= wm1_nxt;
      h_r          <= h_nxt;
      hm1_r        <= hm1_nxt;
      head_r       <= head_nxt;
      in_row_r     <= in_row_nxt;
      in_col_r     <= in_col_nxt;
      out_row_r    <= out_row_nxt;
      out_col_nz_r <= out_col_nz_nxt;
      rcvd_r       <= rcvd_nxt;
    end
  end

  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= h_r)
    else $error("ring head beyond ring size");

  a_rows_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r <= hm1_r) && (out_row_r <= hm1_r))
    else $error("row counter beyond frame height");

  a_read_not_write: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (h_r > AW'(1)) |-> (ring_raddr_c != head_r) && (ring_raddr_b != head_r))
    else $error("ring read collides with write slot");

endmodule

/* hdl/cmnf_filter.sv */
// Median stage with left-neighbor forwarding and the output register.
module cmnf_filter #(
  parameter int RW = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  cmnf_pkg::cmd_t             cmd,
  input  logic [RW-1:0]              cmd_row,
  input  logic [cmnf_pkg::PIX_W-1:0] cmd_right,
  input  logic [cmnf_pkg::PIX_W-1:0] centre_rd,
  input  logic [cmnf_pkg::PIX_W-1:0] below_rd,
  input  logic [cmnf_pkg::PIX_W-1:0] left_rd,
  input  logic                       out_ready,
  output logic                       in_ready,
  output logic                       out_valid,
  output logic [cmnf_pkg::PIX_W-1:0] out_pixel,
  output logic                       out_frame_end,
  output logic                       fcol_we,
  output logic [RW-1:0]              fcol_waddr,
  output logic [cmnf_pkg::PIX_W-1:0] fcol_wdata
);

  logic                       s1_valid_r, s1_valid_nxt;
  cmnf_pkg::cmd_t             cmd_r;
  logic [RW-1:0]              row_r;
  logic [cmnf_pkg::PIX_W-1:0] right_r;
  logic                       fwd_r;
  logic [cmnf_pkg::PIX_W-1:0] fwd_val_r;
  logic [cmnf_pkg::PIX_W-1:0] upper_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [cmnf_pkg::PIX_W-1:0] out_pix_r;
  logic                       out_end_r;

  logic                       s1_go;
  logic                       s1_fire;
  logic                       load;
  cmnf_pkg::word5_t           v;
  logic [cmnf_pkg::PIX_W-1:0] med;

  assign s1_go    = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_ready = !s1_valid_r || s1_go;
  assign load     = acc && cmd.res;

  always_comb begin
    v[0] = centre_rd;
    v[1] = cmd_r.has_left  ? (fwd_r ? fwd_val_r : left_rd) : centre_rd;
    v[2] = cmd_r.has_up    ? upper_r  : centre_rd;
    v[3] = cmd_r.has_right ? right_r  : centre_rd;
    v[4] = cmd_r.has_below ? below_rd : centre_rd;
    med  = cmnf_pkg::median5(v);
  end

  assign fcol_we    = s1_fire;
  assign fcol_waddr = row_r;
  assign fcol_wdata = med;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Same-row write landing on the read edge only happens for a one-row frame.
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r     <= cmd;
      row_r     <= cmd_row;
      right_r   <= cmd_right;
      fwd_r     <= s1_fire && (row_r == cmd_row);
      fwd_val_r <= med;
    end
    if (s1_fire) begin
      upper_r   <= med;
      out_pix_r <= med;
      out_end_r <= cmd_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pix_r;
  assign out_frame_end = out_end_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(row_r))
    else $error("filter stage lost a stalled beat");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r && (out_pix_r == $past(med)))
    else $error("median not captured in output register");

  a_fwd_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    load && s1_fire && (row_r == cmd_row) && cmd.has_left |-> (cmd_row == '0) && !cmd.has_up)
    else $error("left forwarding outside a one-row frame");

endmodule

/* hdl/cross_median_noise_filter.sv */
// Cross median noise filter top level: column-major five-point median over a pixel stream.
// One beat per clock in and out while out_ch.ready is high, with no other stalls from the
// filter itself. A result passes the synchronous read of the raw ring and the
// filtered-column store, then the median network into the output register. Results
// trail the input by one column; the first column produces none, and after the frame
// each further beat (drain or surplus pixel) flushes one pixel of the last column, the
// final one marked with frame_end. Drains before the frame is complete are taken and
// dropped. Stores need no clearing pass after reset. Register writes clamp the size to
// 1..MAX_WIDTH and 1..MAX_HEIGHT and restart the frame.
module cross_median_noise_filter #(
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WIDTH  = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cmnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cmnf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  cmnf_in_if.sink                          in_ch,
  cmnf_out_if.source                       out_ch
);

  localparam int AW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                       acc;
  logic                       in_ready;
  logic                       ring_we;
  logic [AW-1:0]              ring_waddr;
  logic [AW-1:0]              ring_raddr_c;
  logic [AW-1:0]              ring_raddr_b;
  logic [cmnf_pkg::PIX_W-1:0] centre_rd;
  logic [cmnf_pkg::PIX_W-1:0] below_rd;
  logic [RW-1:0]              fcol_raddr;
  logic [cmnf_pkg::PIX_W-1:0] left_rd;
  logic                       fcol_we;
  logic [RW-1:0]              fcol_waddr;
  logic [cmnf_pkg::PIX_W-1:0] fcol_wdata;
  cmnf_pkg::cmd_t             cmd;
  logic [RW-1:0]              cmd_row;

  assign acc         = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  cmnf_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW),
    .RW         (RW),
    .CW         (CW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .acc          (acc),
    .drain        (in_ch.drain),
    .ring_we      (ring_we),
    .ring_waddr   (ring_waddr),
    .ring_raddr_c (ring_raddr_c),
    .ring_raddr_b (ring_raddr_b),
    .fcol_raddr   (fcol_raddr),
    .cmd          (cmd),
    .cmd_row      (cmd_row)
  );

  cmnf_ring_mem #(
    .DEPTH (MAX_HEIGHT + 1),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (in_ch.pixel_in),
    .re      (acc),
    .raddr_a (ring_raddr_c),
    .raddr_b (ring_raddr_b),
    .rdata_a (centre_rd),
    .rdata_b (below_rd)
  );

  cmnf_fcol_mem #(
    .DEPTH (MAX_HEIGHT),
    .RW    (RW)
  ) u_fcol (
    .clk   (clk),
    .we    (fcol_we),
    .waddr (fcol_waddr),
    .wdata (fcol_wdata),
    .re    (acc),
    .raddr (fcol_raddr),
    .rdata (left_rd)
  );

  cmnf_filter #(
    .RW (RW)
  ) u_filter (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .cmd           (cmd),
    .cmd_row       (cmd_row),
    .cmd_right     (in_ch.pixel_in),
    .centre_rd     (centre_rd),
    .below_rd      (below_rd),
    .left_rd       (left_rd),
    .out_ready     (out_ch.ready),
    .in_ready      (in_ready),
    .out_valid     (out_ch.valid),
    .out_pixel     (out_ch.pixel_out),
    .out_frame_end (out_ch.frame_end),
    .fcol_we       (fcol_we),
    .fcol_waddr    (fcol_waddr),
    .fcol_wdata    (fcol_wdata)
  );

endmodule
